/* hdl/assert_macros.svh */
// Assertion helpers used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rstn, expr) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (expr)) \
        else $error("assertion failed: invariant");

// Consequent sequence must follow whenever the antecedent holds.
`define ASSERT_IMPLIES(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed: implication");

`endif

/* hdl/tlbw_pkg.sv */
package tlbw_pkg;

    // Sizing of the page table and the TLB.
    localparam int PT_DEPTH     = 64;
    localparam int MAX_WAYS     = 8;
    localparam int INDEX_BITS   = 2;
    localparam int PPN_BITS     = 16;
    localparam int VA_BITS      = 20;
    localparam int PA_BITS      = 36;
    localparam int AGE_BITS     = 8;
    localparam int NUM_SETS     = 1 << INDEX_BITS;
    localparam int TAG_BITS     = VA_BITS - INDEX_BITS;
    localparam int WAY_BITS     = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int WCNT_BITS    = $clog2(MAX_WAYS + 1);
    localparam int PT_ADDR_BITS = $clog2(PT_DEPTH);
    localparam int PT_CNT_BITS  = $clog2(PT_DEPTH + 1);
    localparam int PT_WORD_BITS = VA_BITS + PPN_BITS + 1;
    localparam logic [AGE_BITS-1:0] AGE_MAX = '1;

    // Configuration register indexes (word address).
    localparam logic REG_WAYS   = 1'b0;
    localparam logic REG_OFFSET = 1'b1;

    typedef enum logic [1:0] {
        ACT_LOAD_PT   = 2'd0,
        ACT_LOAD_TLB  = 2'd1,
        ACT_TRANSLATE = 2'd2
    } action_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_WALK,
        ST_REFILL,
        ST_VICTIM,
        ST_DONE,
        ST_RESP
    } tlbw_state_t;

    typedef struct packed {
        logic                valid;
        logic [TAG_BITS-1:0] tag;
        logic [PPN_BITS-1:0] ppn;
        logic [AGE_BITS-1:0] age;
    } tlb_entry_t;

    typedef struct packed {
        logic                  en;
        logic [INDEX_BITS-1:0] set;
        logic [WAY_BITS-1:0]   way;
        tlb_entry_t            entry;
    } tlb_wr_t;

    // Saturating age increment.
    function automatic logic [AGE_BITS-1:0] age_inc(input logic [AGE_BITS-1:0] age);
        age_inc = (age == AGE_MAX) ? age : age + AGE_BITS'(1);
    endfunction

endpackage

/* hdl/tlbw_tlb.sv */
module tlbw_tlb
    import tlbw_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [INDEX_BITS-1:0] rd_set,
    input  logic [WAY_BITS-1:0]   rd_way,
    output tlb_entry_t            rd_entry,
    input  tlb_wr_t               wr
);

    tlb_entry_t entry_reg [NUM_SETS][MAX_WAYS];

    // One entry is read and one written per cycle; reset clears every entry.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int s = 0; s < NUM_SETS; s++) begin
                for (int w = 0; w < MAX_WAYS; w++) begin
                    entry_reg[s][w] <= '0;
                end
            end
        end else if (wr.en) begin
            entry_reg[wr.set][wr.way] <= wr.entry;
        end
    end

    assign rd_entry = entry_reg[rd_set][rd_way];

endmodule

/* hdl/tlb_with_page_table_walk.sv */
// TLB with page table walk.
// Items arrive on the s_ channel: s_tuser carries the action, s_tdata the
// address and entry fields. Every item produces exactly one result item on
// the m_ channel. Registers ways_in_use (address 0) and offset_bits
// (address 4) are written over the APB port; the user must write them only
// while the block is idle, which the block itself does not enforce. Loads
// of a page table or TLB entry go from acceptance through ST_DONE to ST_RESP.
// A translate steps one TLB way per cycle through the indexed set, then on a
// miss streams the page table memory one entry per cycle through its
// registered read port, then ages the set again, picks the victim and refills it.
// The block takes one item at a time: s_tready is high only when idle, and
// stays low while a result waits, so a stalled receiver holds the block.
// Reset clears the TLB, empties the page table and loads the register
// defaults (4 ways, 12 offset bits); the block is ready right after reset.
module tlb_with_page_table_walk
    import tlbw_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // APB configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Input items
    input  logic        s_tvalid,
    output logic        s_tready,
    // virtual_address[19:0], entry_vpn[39:20], entry_ppn[55:40],
    // entry_valid[56], entry_set[58:57], entry_way[61:59], zero[63:62]
    input  logic [63:0] s_tdata,
    // action[1:0]
    input  logic [1:0]  s_tuser,
    // Result items
    output logic        m_tvalid,
    input  logic        m_tready,
    // tlb_hit[0], page_fault[1], table_full[2], ppn_out[18:3],
    // physical_address[54:19], vpn_out[74:55], set_out[76:75],
    // tag_out[94:77], zero[95]
    output logic [95:0] m_tdata
);

    // Input field split.
    logic [VA_BITS-1:0]  in_va;
    logic [VA_BITS-1:0]  in_evpn;
    logic [PPN_BITS-1:0] in_eppn;
    logic                in_evalid;
    logic [1:0]          in_eset;
    logic [2:0]          in_eway;
    assign in_va     = s_tdata[19:0];
    assign in_evpn   = s_tdata[39:20];
    assign in_eppn   = s_tdata[55:40];
    assign in_evalid = s_tdata[56];
    assign in_eset   = s_tdata[58:57];
    assign in_eway   = s_tdata[61:59];

    // Configuration registers.
    logic [3:0] ways_reg;
    logic [4:0] offset_reg;
    logic       cfg_wr;
    assign cfg_wr = psel & penable & pwrite & pready;
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ways_reg   <= 4'd4;
            offset_reg <= 5'd12;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_WAYS) begin
                ways_reg <= pwdata[3:0];
            end else begin
                offset_reg <= pwdata[4:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == REG_WAYS) begin
            prdata = {28'd0, ways_reg};
        end else begin
            prdata = {27'd0, offset_reg};
        end
    end

    // Sequencer state.
    tlbw_state_t state_reg, state_next;
    action_t                  act_reg, act_next;
    logic [VA_BITS-1:0]       va_reg, va_next;
    logic [VA_BITS-1:0]       vpn_reg, vpn_next;
    logic [INDEX_BITS-1:0]    set_reg, set_next;
    logic [TAG_BITS-1:0]      tag_reg, tag_next;
    logic [WCNT_BITS-1:0]     nways_reg, nways_next;
    logic [WCNT_BITS-1:0]     way_reg, way_next;
    logic                     hit_reg, hit_next;
    logic                     fault_reg, fault_next;
    logic                     full_reg, full_next;
    logic                     found_reg, found_next;
    logic [PPN_BITS-1:0]      ppn_reg, ppn_next;
    logic [PPN_BITS-1:0]      top_reg, top_next;
    logic [AGE_BITS-1:0]      best_reg, best_next;
    logic [WAY_BITS-1:0]      victim_reg, victim_next;
    logic [PT_CNT_BITS-1:0]   count_reg, count_next;
    logic [PT_CNT_BITS-1:0]   idx_reg, idx_next;
    logic                     rdv_reg, rdv_next;

    // Result registers.
    logic                     o_hit_reg, o_hit_next;
    logic                     o_fault_reg, o_fault_next;
    logic                     o_full_reg, o_full_next;
    logic [PPN_BITS-1:0]      o_ppn_reg, o_ppn_next;
    logic [PA_BITS-1:0]       o_pa_reg, o_pa_next;
    logic [VA_BITS-1:0]       o_vpn_reg, o_vpn_next;
    logic [INDEX_BITS-1:0]    o_set_reg, o_set_next;
    logic [TAG_BITS-1:0]      o_tag_reg, o_tag_next;

    // Page table memory: one write and one registered read per cycle.
    logic [PT_WORD_BITS-1:0] pt_mem [PT_DEPTH];
    logic                    pt_we;
    logic [PT_ADDR_BITS-1:0] pt_waddr;
    logic [PT_WORD_BITS-1:0] pt_wdata;
    logic [PT_ADDR_BITS-1:0] pt_raddr;
    logic [PT_WORD_BITS-1:0] pt_rdata_reg;

    always_ff @(posedge aclk) begin
        if (pt_we) begin
            pt_mem[pt_waddr] <= pt_wdata;
        end
        pt_rdata_reg <= pt_mem[pt_raddr];
    end

    logic [VA_BITS-1:0]  rd_vpn;
    logic [PPN_BITS-1:0] rd_ppn;
    logic                rd_valid;
    assign {rd_vpn, rd_ppn, rd_valid} = pt_rdata_reg;

    // TLB storage.
    tlb_entry_t tlb_rd;
    tlb_wr_t    tlb_wr;

    tlbw_tlb u_tlb (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_set  (set_reg),
        .rd_way  (way_reg[WAY_BITS-1:0]),
        .rd_entry(tlb_rd),
        .wr      (tlb_wr)
    );

    // Shared helpers for the sequencer.
    logic [AGE_BITS-1:0]  age_up;
    logic                 tag_match;
    logic                 last_way;
    logic                 pt_has_room;
    logic [VA_BITS-1:0]   in_vpn;
    logic [PPN_BITS-1:0]  new_ppn;
    logic [PA_BITS-1:0]   off_mask;

    assign age_up      = age_inc(tlb_rd.age);
    assign tag_match   = tlb_rd.valid && (tlb_rd.tag == tag_reg);
    assign last_way    = (way_reg + WCNT_BITS'(1)) == nways_reg;
    assign pt_has_room = count_reg < PT_CNT_BITS'(PT_DEPTH);
    assign in_vpn      = in_va >> offset_reg;
    assign new_ppn     = (count_reg != '0) ? top_reg + PPN_BITS'(1) : '0;
    assign off_mask    = (PA_BITS'(1) << offset_reg) - PA_BITS'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            rdv_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            rdv_reg   <= rdv_next;
        end
    end

    always_ff @(posedge aclk) begin
        act_reg     <= act_next;
        va_reg      <= va_next;
        vpn_reg     <= vpn_next;
        set_reg     <= set_next;
        tag_reg     <= tag_next;
        nways_reg   <= nways_next;
        way_reg     <= way_next;
        hit_reg     <= hit_next;
        fault_reg   <= fault_next;
        full_reg    <= full_next;
        found_reg   <= found_next;
        ppn_reg     <= ppn_next;
        top_reg     <= top_next;
        best_reg    <= best_next;
        victim_reg  <= victim_next;
        idx_reg     <= idx_next;
        o_hit_reg   <= o_hit_next;
        o_fault_reg <= o_fault_next;
        o_full_reg  <= o_full_next;
        o_ppn_reg   <= o_ppn_next;
        o_pa_reg    <= o_pa_next;
        o_vpn_reg   <= o_vpn_next;
        o_set_reg   <= o_set_next;
        o_tag_reg   <= o_tag_next;
    end

    // Next state and datapath control.
    always_comb begin
        state_next   = state_reg;
        act_next     = act_reg;
        va_next      = va_reg;
        vpn_next     = vpn_reg;
        set_next     = set_reg;
        tag_next     = tag_reg;
        nways_next   = nways_reg;
        way_next     = way_reg;
        hit_next     = hit_reg;
        fault_next   = fault_reg;
        full_next    = full_reg;
        found_next   = found_reg;
        ppn_next     = ppn_reg;
        top_next     = top_reg;
        best_next    = best_reg;
        victim_next  = victim_reg;
        count_next   = count_reg;
        idx_next     = idx_reg;
        rdv_next     = 1'b0;
        o_hit_next   = o_hit_reg;
        o_fault_next = o_fault_reg;
        o_full_next  = o_full_reg;
        o_ppn_next   = o_ppn_reg;
        o_pa_next    = o_pa_reg;
        o_vpn_next   = o_vpn_reg;
        o_set_next   = o_set_reg;
        o_tag_next   = o_tag_reg;
        pt_we        = 1'b0;
        pt_waddr     = count_reg[PT_ADDR_BITS-1:0];
        pt_wdata     = {in_evpn, in_eppn, in_evalid};
        pt_raddr     = idx_reg[PT_ADDR_BITS-1:0];
        tlb_wr       = '0;
        tlb_wr.set   = set_reg;
        tlb_wr.way   = way_reg[WAY_BITS-1:0];
        tlb_wr.entry = tlb_rd;
        s_tready     = 1'b0;
        m_tvalid     = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    act_next   = action_t'(s_tuser);
                    va_next    = in_va;
                    vpn_next   = in_vpn;
                    set_next   = in_vpn[INDEX_BITS-1:0];
                    tag_next   = in_vpn[VA_BITS-1:INDEX_BITS];
                    hit_next   = 1'b0;
                    fault_next = 1'b0;
                    full_next  = 1'b0;
                    found_next = 1'b0;
                    ppn_next   = '0;
                    top_next   = '0;
                    way_next   = '0;
                    if (ways_reg == 4'd0) begin
                        nways_next = WCNT_BITS'(1);
                    end else if (32'(ways_reg) > MAX_WAYS) begin
                        nways_next = WCNT_BITS'(MAX_WAYS);
                    end else begin
                        nways_next = WCNT_BITS'(ways_reg);
                    end
                    state_next = ST_DONE;
                    case (action_t'(s_tuser))
                        ACT_LOAD_PT: begin
                            if (pt_has_room) begin
                                pt_we      = 1'b1;
                                count_next = count_reg + PT_CNT_BITS'(1);
                            end else begin
                                full_next = 1'b1;
                            end
                        end
                        ACT_LOAD_TLB: begin
                            if (32'(in_eway) < MAX_WAYS) begin
                                tlb_wr.en          = 1'b1;
                                tlb_wr.set         = in_eset[INDEX_BITS-1:0];
                                tlb_wr.way         = in_eway[WAY_BITS-1:0];
                                tlb_wr.entry.valid = in_evalid;
                                tlb_wr.entry.tag   = in_evpn[TAG_BITS-1:0];
                                tlb_wr.entry.ppn   = in_eppn;
                                tlb_wr.entry.age   = AGE_BITS'(in_eset) + AGE_BITS'(in_eway);
                            end
                        end
                        ACT_TRANSLATE: begin
                            state_next = ST_LOOKUP;
                        end
                        default: begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end

            // Age each way of the set in turn until the tag hits or the last way misses.
            ST_LOOKUP: begin
                tlb_wr.en = 1'b1;
                if (tag_match) begin
                    tlb_wr.entry.age = '0;
                    hit_next         = 1'b1;
                    ppn_next         = tlb_rd.ppn;
                    state_next       = ST_DONE;
                end else begin
                    tlb_wr.entry.age = age_up;
                    if (last_way) begin
                        idx_next   = '0;
                        state_next = ST_WALK;
                    end else begin
                        way_next = way_reg + WCNT_BITS'(1);
                    end
                end
            end

            // Stream the page table: first valid match and highest page number; on no match, append a new entry.
            ST_WALK: begin
                if (rdv_reg) begin
                    if (!found_next && rd_valid && (rd_vpn == vpn_reg)) begin
                        found_next = 1'b1;
                        ppn_next   = rd_ppn;
                    end
                    if (rd_ppn > top_reg) begin
                        top_next = rd_ppn;
                    end
                end
                if (idx_reg < count_reg) begin
                    rdv_next = 1'b1;
                    idx_next = idx_reg + PT_CNT_BITS'(1);
                end else if (!rdv_reg) begin
                    way_next    = '0;
                    best_next   = '0;
                    victim_next = '0;
                    state_next  = ST_REFILL;
                    if (!found_reg) begin
                        fault_next = 1'b1;
                        ppn_next   = new_ppn;
                        pt_wdata   = {vpn_reg, new_ppn, 1'b1};
                        if (pt_has_room) begin
                            pt_we      = 1'b1;
                            count_next = count_reg + PT_CNT_BITS'(1);
                        end else begin
                            full_next = 1'b1;
                        end
                    end
                end
            end

            // Age the set again and pick the first oldest way.
            ST_REFILL: begin
                tlb_wr.en        = 1'b1;
                tlb_wr.entry.age = age_up;
                if (age_up > best_reg) begin
                    best_next   = age_up;
                    victim_next = way_reg[WAY_BITS-1:0];
                end
                if (last_way) begin
                    state_next = ST_VICTIM;
                end else begin
                    way_next = way_reg + WCNT_BITS'(1);
                end
            end

            ST_VICTIM: begin
                tlb_wr.en          = 1'b1;
                tlb_wr.way         = victim_reg;
                tlb_wr.entry.valid = 1'b1;
                tlb_wr.entry.tag   = tag_reg;
                tlb_wr.entry.ppn   = ppn_reg;
                tlb_wr.entry.age   = '0;
                state_next         = ST_DONE;
            end

            // Form the result item.
            ST_DONE: begin
                o_full_next  = full_reg;
                o_hit_next   = 1'b0;
                o_fault_next = 1'b0;
                o_ppn_next   = '0;
                o_pa_next    = '0;
                o_vpn_next   = '0;
                o_set_next   = '0;
                o_tag_next   = '0;
                if (act_reg == ACT_TRANSLATE) begin
                    o_hit_next   = hit_reg;
                    o_fault_next = fault_reg;
                    o_vpn_next   = vpn_reg;
                    o_set_next   = set_reg;
                    o_tag_next   = tag_reg;
                    if (!fault_reg) begin
                        o_ppn_next = ppn_reg;
                        o_pa_next  = (PA_BITS'(ppn_reg) << offset_reg)
                                   | (PA_BITS'(va_reg) & off_mask);
                    end
                end
                state_next = ST_RESP;
            end

            ST_RESP: begin
                m_tvalid = 1'b1;
                if (m_tready) begin
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tdata = {1'b0, o_tag_reg, o_set_reg, o_vpn_reg, o_pa_reg, o_ppn_reg,
                      o_full_reg, o_fault_reg, o_hit_reg};

endmodule

/* hdl/tlbw_checker.sv */
`include "assert_macros.svh"

module tlbw_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [95:0] m_tdata
);

    // The block never takes an item while a result is pending.
    `ASSERT_ALWAYS(a_no_overlap, aclk, aresetn, !(s_tready && m_tvalid))

    // Once an item is taken the block is busy on the next cycle.
    `ASSERT_IMPLIES(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready, ##1 !s_tready)

    // A fault reports no hit and no page number.
    `ASSERT_IMPLIES(a_fault_clean, aclk, aresetn, m_tvalid && m_tdata[1], !m_tdata[0] && (m_tdata[18:3] == 16'd0) && (m_tdata[54:19] == 36'd0))

    // A stalled result holds its payload.
    `ASSERT_IMPLIES(a_hold, aclk, aresetn, m_tvalid && !m_tready, ##1 (m_tvalid && $stable(m_tdata)))

endmodule

bind tlb_with_page_table_walk tlbw_checker u_tlbw_checker (.*);
